/* hdl/bcpu_pkg.sv */
`timescale 1ns / 1ps

package bcpu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SIDX_W = $clog2(STACK_DEPTH);

  typedef logic [SIDX_W-1:0] sidx_t;

  // Status register bit positions.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0]  SP_RESET = 8'hFD;
  localparam logic [7:0]  P_RESET  = 8'h20;
  localparam logic [15:0] PC_RESET = 16'h0000;

  typedef enum logic [4:0] {
    OP_BRK = 5'd0,  OP_INX = 5'd1,  OP_INY = 5'd2,  OP_NOP = 5'd3,
    OP_PHA = 5'd4,  OP_PHP = 5'd5,  OP_PLA = 5'd6,  OP_PLP = 5'd7,
    OP_CLC = 5'd8,  OP_CLD = 5'd9,  OP_CLI = 5'd10, OP_CLV = 5'd11,
    OP_DEX = 5'd12, OP_DEY = 5'd13, OP_SEC = 5'd14, OP_SED = 5'd15,
    OP_SEI = 5'd16, OP_TAX = 5'd17, OP_TAY = 5'd18, OP_TSX = 5'd19,
    OP_TXA = 5'd20, OP_TXS = 5'd21, OP_TYA = 5'd22, OP_ADC = 5'd23,
    OP_AND = 5'd24, OP_CMP = 5'd25, OP_CPX = 5'd26, OP_CPY = 5'd27,
    OP_LDX = 5'd28, OP_LDY = 5'd29, OP_LDA = 5'd30, OP_ORA = 5'd31
  } op_t;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] operand;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  stack_ptr_out;
    logic [15:0] pc_out;
    logic [7:0]  status_out;
  } result_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  p;
  } arch_t;

  typedef struct packed {
    logic       en;
    sidx_t      addr;
    logic [7:0] data;
  } stack_wr_t;

endpackage

/* hdl/bcpu_alu.sv */
`timescale 1ns / 1ps

module bcpu_alu (
  input  bcpu_pkg::arch_t     arch,
  input  bcpu_pkg::item_t     item,
  input  logic [7:0]          top,
  output bcpu_pkg::arch_t     arch_next,
  output bcpu_pkg::stack_wr_t wr
);

  bcpu_pkg::op_t op;
  logic [7:0]    v;
  logic [8:0]    adc_sum;
  logic [7:0]    cmp_src;
  logic [8:0]    cmp_diff;
  logic          zn_en;
  logic [7:0]    zn_val;
  logic          push;
  logic [7:0]    push_data;
  bcpu_pkg::arch_t nxt;

  assign op = bcpu_pkg::op_t'(item.mode);
  assign v  = item.operand;

  assign adc_sum = {1'b0, arch.acc} + {1'b0, v} + {8'd0, arch.p[bcpu_pkg::FLAG_C]};

  always_comb begin
    unique case (op)
      bcpu_pkg::OP_CPX: cmp_src = arch.x;
      bcpu_pkg::OP_CPY: cmp_src = arch.y;
      default:          cmp_src = arch.acc;
    endcase
  end

  // The ninth bit is the borrow: clear when the register is at least the operand.
  assign cmp_diff = {1'b0, cmp_src} - {1'b0, v};

  always_comb begin
    nxt       = arch;
    zn_en     = 1'b0;
    zn_val    = 8'd0;
    push      = 1'b0;
    push_data = arch.acc;
    unique case (op)
      bcpu_pkg::OP_BRK: nxt.p[bcpu_pkg::FLAG_B] = 1'b1;
      bcpu_pkg::OP_INX: begin nxt.x = arch.x + 8'd1; zn_en = 1'b1; zn_val = nxt.x; end
      bcpu_pkg::OP_INY: begin nxt.y = arch.y + 8'd1; zn_en = 1'b1; zn_val = nxt.y; end
      bcpu_pkg::OP_NOP: ;
      bcpu_pkg::OP_PHA: begin
        push = 1'b1; push_data = arch.acc; nxt.sp = arch.sp - 8'd1;
      end
      bcpu_pkg::OP_PHP: begin
        push = 1'b1; push_data = arch.p; nxt.sp = arch.sp - 8'd1;
      end
      bcpu_pkg::OP_PLA: begin
        nxt.sp = arch.sp + 8'd1; nxt.acc = top; zn_en = 1'b1; zn_val = top;
      end
      bcpu_pkg::OP_PLP: begin
        nxt.sp = arch.sp + 8'd1;
        nxt.p = top;
        nxt.p[bcpu_pkg::FLAG_U] = 1'b1;
      end
      bcpu_pkg::OP_CLC: nxt.p[bcpu_pkg::FLAG_C] = 1'b0;
      bcpu_pkg::OP_CLD: nxt.p[bcpu_pkg::FLAG_D] = 1'b0;
      bcpu_pkg::OP_CLI: nxt.p[bcpu_pkg::FLAG_I] = 1'b0;
      bcpu_pkg::OP_CLV: nxt.p[bcpu_pkg::FLAG_V] = 1'b0;
      bcpu_pkg::OP_DEX: begin nxt.x = arch.x - 8'd1; zn_en = 1'b1; zn_val = nxt.x; end
      bcpu_pkg::OP_DEY: begin nxt.y = arch.y - 8'd1; zn_en = 1'b1; zn_val = nxt.y; end
      bcpu_pkg::OP_SEC: nxt.p[bcpu_pkg::FLAG_C] = 1'b1;
      bcpu_pkg::OP_SED: nxt.p[bcpu_pkg::FLAG_D] = 1'b1;
      bcpu_pkg::OP_SEI: nxt.p[bcpu_pkg::FLAG_I] = 1'b1;
      bcpu_pkg::OP_TAX: begin nxt.x = arch.acc; zn_en = 1'b1; zn_val = arch.acc; end
      bcpu_pkg::OP_TAY: begin nxt.y = arch.acc; zn_en = 1'b1; zn_val = arch.acc; end
      bcpu_pkg::OP_TSX: begin nxt.x = arch.sp; zn_en = 1'b1; zn_val = arch.sp; end
      bcpu_pkg::OP_TXA: begin nxt.acc = arch.x; zn_en = 1'b1; zn_val = arch.x; end
      bcpu_pkg::OP_TXS: nxt.sp = arch.x;
      bcpu_pkg::OP_TYA: begin nxt.acc = arch.y; zn_en = 1'b1; zn_val = arch.y; end
      bcpu_pkg::OP_ADC: begin
        nxt.acc = adc_sum[7:0];
        nxt.p[bcpu_pkg::FLAG_C] = adc_sum[8];
        // Overflow: both inputs share a sign and the sum's sign differs.
        nxt.p[bcpu_pkg::FLAG_V] = ~(arch.acc[7] ^ v[7]) & (arch.acc[7] ^ adc_sum[7]);
        zn_en = 1'b1; zn_val = adc_sum[7:0];
      end
      bcpu_pkg::OP_AND: begin
        nxt.acc = arch.acc & v; zn_en = 1'b1; zn_val = arch.acc & v;
      end
      bcpu_pkg::OP_CMP, bcpu_pkg::OP_CPX, bcpu_pkg::OP_CPY: begin
        nxt.p[bcpu_pkg::FLAG_C] = ~cmp_diff[8];
        zn_en = 1'b1; zn_val = cmp_diff[7:0];
      end
      bcpu_pkg::OP_LDX: begin nxt.x = v; zn_en = 1'b1; zn_val = v; end
      bcpu_pkg::OP_LDY: begin nxt.y = v; zn_en = 1'b1; zn_val = v; end
      bcpu_pkg::OP_LDA: begin nxt.acc = v; zn_en = 1'b1; zn_val = v; end
      bcpu_pkg::OP_ORA: begin
        nxt.acc = arch.acc | v; zn_en = 1'b1; zn_val = arch.acc | v;
      end
    endcase
    if (zn_en) begin
      nxt.p[bcpu_pkg::FLAG_Z] = (zn_val == 8'd0);
      nxt.p[bcpu_pkg::FLAG_N] = zn_val[7];
    end
    // Operand-carrying operations occupy two bytes of program.
    nxt.pc = arch.pc + ((item.mode >= 5'(bcpu_pkg::OP_ADC)) ? 16'd2 : 16'd1);
  end

  assign arch_next = nxt;
  assign wr.en     = push;
  assign wr.addr   = arch.sp[bcpu_pkg::SIDX_W-1:0];
  assign wr.data   = push_data;

endmodule

/* hdl/bcpu_stack.sv */
`timescale 1ns / 1ps

module bcpu_stack (
  input  logic                clk,
  input  logic                rst,
  input  bcpu_pkg::stack_wr_t wr,
  input  bcpu_pkg::sidx_t     rd_addr,
  output logic [7:0]          top
);

  logic [7:0]                      mem [bcpu_pkg::STACK_DEPTH];
  logic [bcpu_pkg::STACK_DEPTH-1:0] valid;
  logic [7:0]                      mem_q;
  logic                            valid_q;
  logic                            byp_q;
  logic [7:0]                      byp_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q    <= mem[rd_addr];
    byp_data <= wr.data;
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
      byp_q   <= wr.en && (wr.addr == rd_addr);
    end
  end

  // A write in the same cycle as the read of that entry is forwarded.
  assign top = byp_q ? byp_data : (valid_q ? mem_q : 8'd0);

endmodule

/* hdl/byte_cpu_register_flag_execute_unit.sv */
`timescale 1ns / 1ps

// Executes one 8-bit CPU instruction per item and reports the whole
// register file (A, X, Y, stack pointer, program counter, status) after it.
// Input channel: item_valid / item_ready with item (mode, operand).
// Output channel: result_valid / result_ready with result, one per item,
// in order.
// An item accepted into the input register is executed from there, and
// its result is registered when it executes; a stalled result holds the
// item back. Throughput is one item per cycle when the receiver keeps
// result_ready high; the stack store is prefetched at the updated stack
// pointer plus one, so a pull right after a push still issues back
// to back.
// Reset (synchronous, active high) clears A, X, Y and the program counter,
// sets the stack pointer to 0xFD and status to 0x20, drops both pipeline
// valids, and marks every stack entry as zero at once; items are taken
// right after reset.
// When the receiver stalls, the result holds and one more item is held in
// the input register; item_ready then falls until the result is taken.

module byte_cpu_register_flag_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bcpu_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output bcpu_pkg::result_t result
);

  bcpu_pkg::item_t     item_q;
  logic                item_q_valid;
  bcpu_pkg::arch_t     arch;
  bcpu_pkg::arch_t     arch_next;
  bcpu_pkg::arch_t     exec_arch;
  bcpu_pkg::stack_wr_t exec_wr;
  bcpu_pkg::stack_wr_t wr;
  bcpu_pkg::sidx_t     rd_addr;
  logic [7:0]          rd_sp;
  logic [7:0]          top;
  logic                exec_fire;

  assign exec_fire  = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  bcpu_alu u_alu (
    .arch      (arch),
    .item      (item_q),
    .top       (top),
    .arch_next (exec_arch),
    .wr        (exec_wr)
  );

  assign arch_next = exec_fire ? exec_arch : arch;
  assign wr.en     = exec_fire && exec_wr.en;
  assign wr.addr   = exec_wr.addr;
  assign wr.data   = exec_wr.data;

  // Prefetch the entry a pull would read after this cycle's update.
  assign rd_sp   = arch_next.sp + 8'd1;
  assign rd_addr = rd_sp[bcpu_pkg::SIDX_W-1:0];

  bcpu_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .top     (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arch.acc <= 8'd0;
      arch.x   <= 8'd0;
      arch.y   <= 8'd0;
      arch.sp  <= bcpu_pkg::SP_RESET;
      arch.pc  <= bcpu_pkg::PC_RESET;
      arch.p   <= bcpu_pkg::P_RESET;
    end else begin
      arch <= arch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result.acc_out       <= exec_arch.acc;
      result.index_x_out   <= exec_arch.x;
      result.index_y_out   <= exec_arch.y;
      result.stack_ptr_out <= exec_arch.sp;
      result.pc_out        <= exec_arch.pc;
      result.status_out    <= exec_arch.p;
    end
  end

endmodule

/* hdl/bcpu_checker.sv */
`timescale 1ns / 1ps

module bcpu_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input bcpu_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input bcpu_pkg::result_t result
);

  // A reset edge leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Input backpressure only ever comes from a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without a stalled result");

  a_unused_bit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status_out[bcpu_pkg::FLAG_U])
    else $error("unused status bit clear");

  a_item_holds: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("waiting item changed");

endmodule

bind byte_cpu_register_flag_execute_unit bcpu_checker u_bcpu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
